// ===== design/slcm_pkg.sv =====
// Types, widths and multiplier helpers for the skew-line closest midpoint pipeline.
// No dependencies; imported by skew_line_closest_midpoint.
package slcm_pkg;

   localparam int unsigned DIV_STEPS  = 32;
   localparam int unsigned MAG_W      = 168;
   localparam int unsigned DEN2_W     = 134;
   localparam int unsigned NUM_STAGES = 11 + DIV_STEPS;

   typedef logic signed [32:0]  diff_type;
   typedef logic signed [65:0]  sprod_type;
   typedef logic signed [66:0]  cross_type;
   typedef logic signed [133:0] prod_type;
   typedef logic signed [135:0] dot_type;
   typedef logic signed [167:0] wide_type;
   typedef logic [MAG_W-1:0]    mag_type;
   typedef logic [DEN2_W-1:0]   den2_type;

   // partial products of a 67 x 67 signed multiply, split at bit 34
   typedef struct packed {
      logic signed [65:0] hh;
      logic signed [67:0] hl;
      logic signed [67:0] lh;
      logic        [67:0] ll;
   } pp67_type;

   // partial products of a 136 x 33 signed multiply, wide side cut in 34-bit slices
   typedef struct packed {
      logic signed [67:0] p0;
      logic signed [67:0] p1;
      logic signed [67:0] p2;
      logic signed [66:0] p3;
   } pp136_type;

   function automatic sprod_type mul33(input diff_type a, input diff_type b);
      mul33 = a * b;
   endfunction

   function automatic pp67_type mul67_pp(input cross_type a, input cross_type b);
      logic signed [32:0] ah;
      logic signed [32:0] bh;
      logic signed [34:0] al;
      logic signed [34:0] bl;
      pp67_type r;
      ah   = a[66:34];
      bh   = b[66:34];
      al   = $signed({1'b0, a[33:0]});
      bl   = $signed({1'b0, b[33:0]});
      r.hh = ah * bh;
      r.hl = ah * bl;
      r.lh = al * bh;
      r.ll = a[33:0] * b[33:0];
      return r;
   endfunction

   function automatic prod_type pp67_sum(input pp67_type p);
      return (134'(p.hh) <<< 68) + (134'(p.hl) <<< 34) + (134'(p.lh) <<< 34)
             + 134'(p.ll);
   endfunction

   function automatic pp136_type mul136_pp(input dot_type b, input diff_type x);
      logic signed [34:0] b0;
      logic signed [34:0] b1;
      logic signed [34:0] b2;
      logic signed [33:0] b3;
      pp136_type r;
      b0   = $signed({1'b0, b[33:0]});
      b1   = $signed({1'b0, b[67:34]});
      b2   = $signed({1'b0, b[101:68]});
      b3   = b[135:102];
      r.p0 = b0 * x;
      r.p1 = b1 * x;
      r.p2 = b2 * x;
      r.p3 = b3 * x;
      return r;
   endfunction

   function automatic wide_type pp136_sum(input pp136_type p);
      return (168'(p.p3) <<< 102) + (168'(p.p2) <<< 68) + (168'(p.p1) <<< 34)
             + 168'(p.p0);
   endfunction

endpackage

// ===== design/skew_line_closest_midpoint.sv =====
// Closest-approach midpoint of two 3D lines in signed Q16.16.
// Depends on slcm_pkg (types, widths, split-multiplier helpers).

// Each beat carries two lines as two points each; each result beat carries the
// midpoint of the closest approach, rounded to nearest (ties away from zero),
// with a parallel flag (coordinates zero) and a saturation flag. The pipeline
// takes one beat per cycle unless the result side stalls. It has 11 stages of
// differences, cross and dot products (wide multiplies cut into 34-bit partial
// products), then one quotient bit per stage over 32 restoring-division stages
// for all three coordinates, then a saturation/output stage. A stall on the
// result side holds the whole pipeline.
module skew_line_closest_midpoint import slcm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_line1_a_x,
   input  logic signed [31:0] req_line1_a_y,
   input  logic signed [31:0] req_line1_a_z,
   input  logic signed [31:0] req_line1_b_x,
   input  logic signed [31:0] req_line1_b_y,
   input  logic signed [31:0] req_line1_b_z,
   input  logic signed [31:0] req_line2_a_x,
   input  logic signed [31:0] req_line2_a_y,
   input  logic signed [31:0] req_line2_a_z,
   input  logic signed [31:0] req_line2_b_x,
   input  logic signed [31:0] req_line2_b_y,
   input  logic signed [31:0] req_line2_b_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_mid_x,
   output logic signed [31:0] rsp_mid_y,
   output logic signed [31:0] rsp_mid_z,
   output logic               rsp_parallel_flag,
   output logic               rsp_saturated_flag
);

   logic adv;
   logic [NUM_STAGES-1:0] vld_ff;
   logic rsp_valid_ff;

   logic signed [31:0] a1 [3];
   logic signed [31:0] b1 [3];
   logic signed [31:0] a2 [3];
   logic signed [31:0] b2 [3];

   assign a1[0] = req_line1_a_x;  assign a1[1] = req_line1_a_y;  assign a1[2] = req_line1_a_z;
   assign b1[0] = req_line1_b_x;  assign b1[1] = req_line1_b_y;  assign b1[2] = req_line1_b_z;
   assign a2[0] = req_line2_a_x;  assign a2[1] = req_line2_a_y;  assign a2[2] = req_line2_a_z;
   assign b2[0] = req_line2_b_x;  assign b2[1] = req_line2_b_y;  assign b2[2] = req_line2_b_z;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NUM_STAGES-2:0], req_valid};
         rsp_valid_ff <= vld_ff[NUM_STAGES-1];
      end
   end

   // stage 1..6 carry of the point sums and directions, needed again at stage 7
   diff_type s_ff  [1:6][3];
   diff_type d1_ff [1:6][3];
   diff_type d2_ff [1:6][3];
   diff_type w_ff  [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[1][k]  <= 33'(a1[k]) + 33'(a2[k]);
            d1_ff[1][k] <= 33'(b1[k]) - 33'(a1[k]);
            d2_ff[1][k] <= 33'(b2[k]) - 33'(a2[k]);
            w_ff[k]     <= 33'(a2[k]) - 33'(a1[k]);
            for (int st = 2; st <= 6; st++) begin
               s_ff[st][k]  <= s_ff[st-1][k];
               d1_ff[st][k] <= d1_ff[st-1][k];
               d2_ff[st][k] <= d2_ff[st-1][k];
            end
         end
      end
   end

   // stage 2: products of the three cross products c = d1 x d2, e = w x d2, f = w x d1
   sprod_type cpa_ff [3], cpb_ff [3], epa_ff [3], epb_ff [3], fpa_ff [3], fpb_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         cpa_ff[0] <= mul33(d1_ff[1][1], d2_ff[1][2]);
         cpb_ff[0] <= mul33(d1_ff[1][2], d2_ff[1][1]);
         cpa_ff[1] <= mul33(d1_ff[1][2], d2_ff[1][0]);
         cpb_ff[1] <= mul33(d1_ff[1][0], d2_ff[1][2]);
         cpa_ff[2] <= mul33(d1_ff[1][0], d2_ff[1][1]);
         cpb_ff[2] <= mul33(d1_ff[1][1], d2_ff[1][0]);
         epa_ff[0] <= mul33(w_ff[1], d2_ff[1][2]);
         epb_ff[0] <= mul33(w_ff[2], d2_ff[1][1]);
         epa_ff[1] <= mul33(w_ff[2], d2_ff[1][0]);
         epb_ff[1] <= mul33(w_ff[0], d2_ff[1][2]);
         epa_ff[2] <= mul33(w_ff[0], d2_ff[1][1]);
         epb_ff[2] <= mul33(w_ff[1], d2_ff[1][0]);
         fpa_ff[0] <= mul33(w_ff[1], d1_ff[1][2]);
         fpb_ff[0] <= mul33(w_ff[2], d1_ff[1][1]);
         fpa_ff[1] <= mul33(w_ff[2], d1_ff[1][0]);
         fpb_ff[1] <= mul33(w_ff[0], d1_ff[1][2]);
         fpa_ff[2] <= mul33(w_ff[0], d1_ff[1][1]);
         fpb_ff[2] <= mul33(w_ff[1], d1_ff[1][0]);
      end
   end

   // stages 3..6: cross products, split dot-product multiplies, dot sums
   cross_type c_ff [3], e_ff [3], f_ff [3];
   pp67_type  ppd_ff [3], ppn1_ff [3], ppn2_ff [3];
   prod_type  pd_ff [3], pn1_ff [3], pn2_ff [3];
   dot_type   den6_ff, num1_ff, num2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            c_ff[k]    <= 67'(cpa_ff[k]) - 67'(cpb_ff[k]);
            e_ff[k]    <= 67'(epa_ff[k]) - 67'(epb_ff[k]);
            f_ff[k]    <= 67'(fpa_ff[k]) - 67'(fpb_ff[k]);
            ppd_ff[k]  <= mul67_pp(c_ff[k], c_ff[k]);
            ppn1_ff[k] <= mul67_pp(e_ff[k], c_ff[k]);
            ppn2_ff[k] <= mul67_pp(f_ff[k], c_ff[k]);
            pd_ff[k]   <= pp67_sum(ppd_ff[k]);
            pn1_ff[k]  <= pp67_sum(ppn1_ff[k]);
            pn2_ff[k]  <= pp67_sum(ppn2_ff[k]);
         end
         den6_ff <= 136'(pd_ff[0]) + 136'(pd_ff[1]) + 136'(pd_ff[2]);
         num1_ff <= 136'(pn1_ff[0]) + 136'(pn1_ff[1]) + 136'(pn1_ff[2]);
         num2_ff <= 136'(pn2_ff[0]) + 136'(pn2_ff[1]) + 136'(pn2_ff[2]);
      end
   end

   // stages 7..9: numerator n = den*(a1+a2) + num1*d1 + num2*d2 per coordinate
   pp136_type pps_ff [3], ppa_ff [3], ppb_ff [3];
   wide_type  ws_ff [3], wa_ff [3], wb_ff [3];
   wide_type  n_ff [3];
   dot_type   den7_ff, den8_ff, den9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            pps_ff[k] <= mul136_pp(den6_ff, s_ff[6][k]);
            ppa_ff[k] <= mul136_pp(num1_ff, d1_ff[6][k]);
            ppb_ff[k] <= mul136_pp(num2_ff, d2_ff[6][k]);
            ws_ff[k]  <= pp136_sum(pps_ff[k]);
            wa_ff[k]  <= pp136_sum(ppa_ff[k]);
            wb_ff[k]  <= pp136_sum(ppb_ff[k]);
            n_ff[k]   <= ws_ff[k] + wa_ff[k] + wb_ff[k];
         end
         den7_ff <= den6_ff;
         den8_ff <= den7_ff;
         den9_ff <= den8_ff;
      end
   end

   // stage 10: sign and rounded magnitude |n| + den; divisor is 2*den
   logic     neg10_ff [3];
   mag_type  mag10_ff [3];
   den2_type den2_10_ff;
   logic     par10_ff;
   mag_type  mag_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = (n_ff[k][MAG_W-1] ? mag_type'(-n_ff[k]) : mag_type'(n_ff[k]))
                     + mag_type'(den9_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            neg10_ff[k] <= n_ff[k][MAG_W-1];
            mag10_ff[k] <= mag_in[k];
         end
         den2_10_ff <= {den9_ff[DEN2_W-2:0], 1'b0};
         par10_ff   <= (den9_ff == '0);
      end
   end

   // stage 11 .. 11+DIV_STEPS: overflow check, then one quotient bit per stage
   mag_type             rem_ff  [DIV_STEPS+1][3];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS+1][3];
   logic                neg_ff  [DIV_STEPS+1][3];
   logic                high_ff [DIV_STEPS+1][3];
   den2_type            den2_ff [DIV_STEPS+1];
   logic                par_ff  [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            rem_ff[0][k]  <= mag10_ff[k];
            q_ff[0][k]    <= '0;
            neg_ff[0][k]  <= neg10_ff[k];
            high_ff[0][k] <= (mag10_ff[k] >= (mag_type'(den2_10_ff) << DIV_STEPS));
         end
         den2_ff[0] <= den2_10_ff;
         par_ff[0]  <= par10_ff;
      end
   end

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      localparam int unsigned BIT = DIV_STEPS - 1 - s;
      mag_type dvs;
      logic    take [3];

      assign dvs = mag_type'(den2_ff[s]) << BIT;

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            take[k] = (rem_ff[s][k] >= dvs);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int k = 0; k < 3; k++) begin
               rem_ff[s+1][k]  <= take[k] ? rem_ff[s][k] - dvs : rem_ff[s][k];
               q_ff[s+1][k]    <= q_ff[s][k] | (DIV_STEPS'(take[k]) << BIT);
               neg_ff[s+1][k]  <= neg_ff[s][k];
               high_ff[s+1][k] <= high_ff[s][k];
            end
            den2_ff[s+1] <= den2_ff[s];
            par_ff[s+1]  <= par_ff[s];
         end
      end
   end

   // output stage: clip to the signed 32-bit range, zero on parallel lines
   logic signed [31:0] mid_in [3];
   logic               clip_in [3];
   logic signed [31:0] mid_ff [3];
   logic               par_out_ff, sat_out_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [31:0] qv;
         qv = q_ff[DIV_STEPS][k];
         if (neg_ff[DIV_STEPS][k]) begin
            clip_in[k] = high_ff[DIV_STEPS][k] || (qv > 32'h8000_0000);
            mid_in[k]  = clip_in[k] ? $signed(32'h8000_0000) : $signed(32'd0 - qv);
         end else begin
            clip_in[k] = high_ff[DIV_STEPS][k] || qv[31];
            mid_in[k]  = clip_in[k] ? $signed(32'h7FFF_FFFF) : $signed(qv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            mid_ff[k] <= par_ff[DIV_STEPS] ? '0 : mid_in[k];
         end
         par_out_ff <= par_ff[DIV_STEPS];
         sat_out_ff <= !par_ff[DIV_STEPS] && (clip_in[0] || clip_in[1] || clip_in[2]);
      end
   end

   assign rsp_mid_x          = mid_ff[0];
   assign rsp_mid_y          = mid_ff[1];
   assign rsp_mid_z          = mid_ff[2];
   assign rsp_parallel_flag  = par_out_ff;
   assign rsp_saturated_flag = sat_out_ff;

endmodule
